### src/cobs_fd_pkg.sv
// Shared widths, constants and defaults for the COBS frame decoder.
`timescale 1ns / 1ps

package cobs_fd_pkg;

  // Payload widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 13;

  // Special byte values of the COBS format.
  localparam logic [BYTE_W-1:0] CODE_FULL = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

  // Default frame capacity and reset value of the length limit register.
  localparam int unsigned MAX_FRAME_BYTES_DEF = 4096;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET  = 13'd4096;

  // Largest value a length field can hold.
  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;

endpackage

### src/cobs_fd_in_if.sv
// Input channel of the COBS frame decoder: one encoded byte per beat.
`timescale 1ns / 1ps

interface cobs_fd_in_if;
  logic                             valid;
  logic                             ready;
  logic [cobs_fd_pkg::BYTE_W-1:0]   in_byte;
  logic                             last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

### src/cobs_fd_out_if.sv
// Result channel of the COBS frame decoder: one result per input beat.
`timescale 1ns / 1ps

interface cobs_fd_out_if;
  logic                             valid;
  logic                             ready;
  logic                             out_valid;
  logic [cobs_fd_pkg::BYTE_W-1:0]   out_byte;
  logic                             frame_done;
  logic                             frame_error;
  logic [cobs_fd_pkg::LEN_W-1:0]    frame_length;

  modport source (output valid, output out_valid, output out_byte, output frame_done,
                  output frame_error, output frame_length, input ready);
  modport sink   (input valid, input out_valid, input out_byte, input frame_done,
                  input frame_error, input frame_length, output ready);
endinterface

### src/cobs_frame_decoder.sv
// Top level of the streaming COBS frame decoder.
`timescale 1ns / 1ps

// Usage:
//   in_i carries one encoded byte per beat, with last_byte set on the final
//   byte of the frame; a 0x00 in that final byte is taken as the delimiter.
//   out_o carries exactly one result beat per input beat: out_valid and
//   out_byte give a decoded byte (copied, or an inserted zero), and on the
//   result of the final byte frame_done is set together with frame_error
//   and frame_length (0 when the frame failed).
//   cfg_we_i / cfg_wdata_i write the per-frame output limit; the limit in
//   force is the smaller of that register and MAX_FRAME_BYTES. Write it
//   only between frames while no result is pending.
//   The result beat of an accepted input beat appears in the next cycle.
//   Throughput is one byte per cycle while the receiver does not stall:
//   the decode step is a byte compare and a counter update feeding a
//   single result register. When the receiver stalls, the result register
//   holds its beat and the input is stalled in the same cycle; the input is
//   taken again in the cycle the held beat leaves. Reset empties the result
//   register, clears the frame state and sets the limit register to 4096.
module cobs_frame_decoder #(
  parameter int unsigned MAX_FRAME_BYTES = cobs_fd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cobs_fd_in_if.sink                      in_i,
  cobs_fd_out_if.source                   out_o,
  input  logic                            cfg_we_i,
  input  logic [cobs_fd_pkg::LEN_W-1:0]   cfg_wdata_i
);

  localparam int unsigned BW = cobs_fd_pkg::BYTE_W;
  localparam int unsigned LW = cobs_fd_pkg::LEN_W;
  // Frame capacity clipped to what the length field can express.
  localparam int unsigned CAP_INT = (MAX_FRAME_BYTES < cobs_fd_pkg::LEN_MAX) ?
                                    MAX_FRAME_BYTES : cobs_fd_pkg::LEN_MAX;
  localparam logic [LW-1:0] CAP = LW'(CAP_INT);

  // Configuration and frame state.
  logic [LW-1:0] max_len_q;
  logic [BW-1:0] grp_rem_q, grp_rem_d;
  logic          full_q, full_d;
  logic          first_q, first_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          err_q, err_d;

  // Result register.
  logic          res_vld_q;
  logic          ov_q, ov_d;
  logic [BW-1:0] ob_q, ob_d;
  logic          done_q, done_d;
  logic          ferr_q, ferr_d;
  logic [LW-1:0] flen_q, flen_d;

  logic          accept;
  logic          is_delim;
  logic          want_emit;
  logic [BW-1:0] emit_val;
  logic          overflow;
  logic          emit;
  logic          err_step;
  logic [BW-1:0] grp_step;
  logic          trunc_err;
  logic [LW-1:0] limit;

  // Handshake: a new beat enters whenever the result register is free or leaving.
  assign in_i.ready = !res_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= cobs_fd_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign limit = (max_len_q < CAP) ? max_len_q : CAP;

  // Decode one byte against the frame state.
  always_comb begin
    is_delim  = in_i.last_byte && (in_i.in_byte == cobs_fd_pkg::BYTE_ZERO);
    want_emit = 1'b0;
    emit_val  = cobs_fd_pkg::BYTE_ZERO;
    err_step  = err_q;
    grp_rem_d = grp_rem_q;
    full_d    = full_q;
    first_d   = first_q;

    if (!err_q && !is_delim) begin
      if (grp_rem_q != '0) begin
        // Data byte inside a group is copied out.
        want_emit = 1'b1;
        emit_val  = in_i.in_byte;
        grp_rem_d = grp_rem_q - BW'(1);
      end else if (in_i.in_byte == cobs_fd_pkg::BYTE_ZERO) begin
        err_step = 1'b1;
      end else begin
        // Code byte: insert the zero that ended the previous short group.
        want_emit = !first_q && !full_q;
      end
    end

    overflow = want_emit && (cnt_q >= limit);
    emit     = want_emit && !overflow;
    if (overflow) begin
      err_step = 1'b1;
    end

    // A code byte opens its group only if no error arose in this step.
    if (!err_q && !is_delim && (grp_rem_q == '0) && !err_step) begin
      grp_rem_d = in_i.in_byte - BW'(1);
      full_d    = (in_i.in_byte == cobs_fd_pkg::CODE_FULL);
      first_d   = 1'b0;
    end
    grp_step = grp_rem_d;

    cnt_d     = emit ? (cnt_q + LW'(1)) : cnt_q;
    trunc_err = !err_step && (grp_step != '0);
    err_d     = err_step;

    ov_d   = emit;
    ob_d   = emit ? emit_val : cobs_fd_pkg::BYTE_ZERO;
    done_d = in_i.last_byte;
    ferr_d = in_i.last_byte && (err_step || trunc_err);
    flen_d = (in_i.last_byte && !(err_step || trunc_err)) ? cnt_d : '0;

    // Frame end clears the frame state for the next frame.
    if (in_i.last_byte) begin
      grp_rem_d = '0;
      full_d    = 1'b0;
      first_d   = 1'b1;
      cnt_d     = '0;
      err_d     = 1'b0;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_rem_q <= '0;
      full_q    <= 1'b0;
      first_q   <= 1'b1;
      cnt_q     <= '0;
      err_q     <= 1'b0;
    end else if (accept) begin
      grp_rem_q <= grp_rem_d;
      full_q    <= full_d;
      first_q   <= first_d;
      cnt_q     <= cnt_d;
      err_q     <= err_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (accept) begin
      res_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ov_q   <= ov_d;
      ob_q   <= ob_d;
      done_q <= done_d;
      ferr_q <= ferr_d;
      flen_q <= flen_d;
    end
  end

  assign out_o.valid        = res_vld_q;
  assign out_o.out_valid    = ov_q;
  assign out_o.out_byte     = ob_q;
  assign out_o.frame_done   = done_q;
  assign out_o.frame_error  = ferr_q;
  assign out_o.frame_length = flen_q;

  // A failed frame reports no length.
  a_err_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frame_error) |-> (out_o.frame_length == '0))
    else $error("frame_error reported with nonzero frame_length");

  // Once an error is latched, a non-final beat emits nothing.
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && err_q && !in_i.last_byte) |=> (out_o.valid && !out_o.out_valid))
    else $error("decoded byte emitted after frame error");

  // The result of a final beat leaves the frame state cleared.
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.last_byte) |=> (cnt_q == '0 && !err_q && first_q && grp_rem_q == '0))
    else $error("frame state not cleared after frame end");

  // An empty result register never stalls the input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_vld_q |-> in_i.ready)
    else $error("input stalled with empty result register");

endmodule

### bench/cobs_decode_checker.sv
// Checker for the COBS frame decoder: predicts each result beat and compares it.
`timescale 1ns / 1ps

module cobs_decode_checker #(
  parameter int unsigned MAX_FRAME_BYTES = cobs_fd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cobs_fd_in_if                          in_mon_i,
  cobs_fd_out_if                         out_mon_i,
  input  logic                           cfg_we_i,
  input  logic [cobs_fd_pkg::LEN_W-1:0]  cfg_wdata_i,
  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);

  typedef struct packed {
    logic                           out_valid;
    logic [cobs_fd_pkg::BYTE_W-1:0] out_byte;
    logic                           frame_done;
    logic                           frame_error;
    logic [cobs_fd_pkg::LEN_W-1:0]  frame_length;
  } decoded_beat_t;

  // Mirror of the decoder's frame state and its length limit register.
  logic [cobs_fd_pkg::LEN_W-1:0]  len_limit_q;
  logic [cobs_fd_pkg::BYTE_W-1:0] grp_left;
  logic                           prev_full;
  logic                           first_grp;
  int unsigned                    out_count;
  logic                           err_seen;

  // Result beats still owed by the decoder, oldest first.
  decoded_beat_t decoded_beats_q [$];

  function automatic void clear_frame_state();
    grp_left  = '0;
    prev_full = 1'b0;
    first_grp = 1'b1;
    out_count = 0;
    err_seen  = 1'b0;
  endfunction

  // Emits one byte unless the limit in force is already reached.
  function automatic void emit_byte(input logic [cobs_fd_pkg::BYTE_W-1:0] value,
                                    inout decoded_beat_t beat);
    int unsigned cap;
    cap = (32'(len_limit_q) < MAX_FRAME_BYTES) ? 32'(len_limit_q) : MAX_FRAME_BYTES;
    if (out_count >= cap) begin
      err_seen = 1'b1;
    end else begin
      beat.out_valid = 1'b1;
      beat.out_byte  = value;
      out_count++;
    end
  endfunction

  // Decodes one encoded byte and returns the result beat it should cause.
  function automatic decoded_beat_t decode_byte(input logic [cobs_fd_pkg::BYTE_W-1:0] b,
                                                input logic last);
    decoded_beat_t beat;
    beat = '0;
    // A trailing zero on the last byte is the delimiter and decodes to nothing.
    if (!err_seen && !(last && b == cobs_fd_pkg::BYTE_ZERO)) begin
      if (grp_left != '0) begin
        emit_byte(b, beat);
        grp_left = grp_left - 8'd1;
      end else if (b == cobs_fd_pkg::BYTE_ZERO) begin
        err_seen = 1'b1;
      end else begin
        // A new code byte after a short group stands for a zero in the data.
        if (!first_grp && !prev_full) begin
          emit_byte(cobs_fd_pkg::BYTE_ZERO, beat);
        end
        if (!err_seen) begin
          grp_left  = b - 8'd1;
          prev_full = (b == cobs_fd_pkg::CODE_FULL);
          first_grp = 1'b0;
        end
      end
    end
    // Frame end reports the outcome and a group left open is a truncation.
    if (last) begin
      if (!err_seen && grp_left != '0) begin
        err_seen = 1'b1;
      end
      beat.frame_done   = 1'b1;
      beat.frame_error  = err_seen;
      beat.frame_length = err_seen ? '0 : cobs_fd_pkg::LEN_W'(out_count);
      clear_frame_state();
    end
    return beat;
  endfunction

  // Track configuration, predict on input beats and compare on result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    decoded_beat_t want;
    decoded_beat_t got;
    if (!rst_ni) begin
      len_limit_q = cobs_fd_pkg::MAX_LEN_RESET;
      clear_frame_state();
      decoded_beats_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        len_limit_q = cfg_wdata_i;
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        decoded_beats_q.push_back(decode_byte(in_mon_i.in_byte, in_mon_i.last_byte));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.out_valid    = out_mon_i.out_valid;
        got.out_byte     = out_mon_i.out_byte;
        got.frame_done   = out_mon_i.frame_done;
        got.frame_error  = out_mon_i.frame_error;
        got.frame_length = out_mon_i.frame_length;
        if (decoded_beats_q.size() == 0) begin
          $error("result beat with no input beat waiting for it");
          fail_count_o++;
        end else begin
          want = decoded_beats_q.pop_front();
          if (got.out_valid !== want.out_valid) begin
            $error("out_valid: expected %0b, actual %0b", want.out_valid, got.out_valid);
            fail_count_o++;
          end
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.out_byte, got.out_byte);
            fail_count_o++;
          end
          if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, actual %0b", want.frame_done, got.frame_done);
            fail_count_o++;
          end
          if (got.frame_error !== want.frame_error) begin
            $error("frame_error: expected %0b, actual %0b", want.frame_error,
                   got.frame_error);
            fail_count_o++;
          end
          if (got.frame_length !== want.frame_length) begin
            $error("frame_length: expected %0d, actual %0d", want.frame_length,
                   got.frame_length);
            fail_count_o++;
          end
        end
      end
      pending_o <= decoded_beats_q.size();
    end
  end

endmodule

### bench/tb_cobs_frame_decoder.sv
// Testbench top for the COBS frame decoder: stimulus, limit settings and verdict.
`timescale 1ns / 1ps

module tb_cobs_frame_decoder;

  typedef logic [cobs_fd_pkg::BYTE_W-1:0] byte_q_t [$];

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [cobs_fd_pkg::LEN_W-1:0] cfg_wdata;
  logic                          idle_on;
  int unsigned                   bytes_sent;
  int unsigned                   pending;
  int unsigned                   fail_count;

  cobs_fd_in_if  in_ch ();
  cobs_fd_out_if out_ch ();

  cobs_frame_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  cobs_decode_checker decode_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Clock with an 8 ns period.
  always #4 clk = ~clk;

  // The receiver stalls at random while idling is enabled.
  always @(posedge clk) begin
    out_ch.ready <= !idle_on || ($urandom_range(99) >= 31);
  end

  // Offers one encoded byte, with random gaps, and returns once it is taken.
  task automatic push_encoded_byte(input logic [cobs_fd_pkg::BYTE_W-1:0] b, input logic last);
    while (idle_on && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  task automatic push_frame(input byte_q_t frame);
    foreach (frame[i]) begin
      push_encoded_byte(frame[i], i == frame.size() - 1);
    end
  endtask

  // Stops sending and waits until every owed result beat has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending != 0);
  endtask

  task automatic write_limit(input logic [cobs_fd_pkg::LEN_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Standard COBS encoding, runs of 254 nonzero bytes closing with a 0xFF code.
  function automatic void encode_cobs(input byte_q_t raw, output byte_q_t enc);
    int unsigned                    code_pos;
    logic [cobs_fd_pkg::BYTE_W-1:0] code;
    enc      = {};
    enc.push_back(cobs_fd_pkg::BYTE_ZERO);
    code_pos = 0;
    code     = 8'd1;
    foreach (raw[i]) begin
      if (raw[i] == cobs_fd_pkg::BYTE_ZERO) begin
        enc[code_pos] = code;
        enc.push_back(cobs_fd_pkg::BYTE_ZERO);
        code_pos = enc.size() - 1;
        code     = 8'd1;
      end else begin
        enc.push_back(raw[i]);
        code++;
        if (code == cobs_fd_pkg::CODE_FULL) begin
          enc[code_pos] = code;
          enc.push_back(cobs_fd_pkg::BYTE_ZERO);
          code_pos = enc.size() - 1;
          code     = 8'd1;
        end
      end
    end
    enc[code_pos] = code;
  endfunction

  // Builds a valid encoded frame from random data, mostly short.
  function automatic void build_frame(output byte_q_t enc);
    byte_q_t     raw;
    int unsigned len;
    int unsigned zero_pct;
    if ($urandom_range(99) < 4) begin
      len      = $urandom_range(300, 250);
      zero_pct = 1;
    end else begin
      len      = $urandom_range(16, 0);
      zero_pct = 20;
    end
    raw = {};
    repeat (len) begin
      raw.push_back(($urandom_range(99) < zero_pct) ? cobs_fd_pkg::BYTE_ZERO :
                    8'($urandom_range(255, 1)));
    end
    encode_cobs(raw, enc);
    if ($urandom_range(1)) begin
      enc.push_back(cobs_fd_pkg::BYTE_ZERO);
    end
  endfunction

  // Mostly valid frames with random content, mixed with damaged frames and noise.
  task automatic run_random(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned idx;
    byte_q_t     frame;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 90) begin
        build_frame(frame);
      end
      if (pick >= 75 && pick < 90) begin
        idx = $urandom_range(frame.size() - 1);
        case ($urandom_range(2))
          0: begin
            // Cut the frame short.
            if (frame.size() > 1) begin
              repeat ($urandom_range(frame.size() - 1, 1)) void'(frame.pop_back());
            end
          end
          1: frame[idx] = cobs_fd_pkg::BYTE_ZERO;
          default: frame[idx] = 8'($urandom_range(255));
        endcase
      end else if (pick >= 90) begin
        frame = {};
        repeat ($urandom_range(8, 1)) frame.push_back(8'($urandom_range(255)));
      end
      push_frame(frame);
    end
  endtask

  // Directed frames covering the special cases at the reset limit.
  task automatic run_directed();
    byte_q_t frame;
    // Empty frames: a lone delimiter and a lone 0x01 code.
    frame = '{8'h00};
    push_frame(frame);
    frame = '{8'h01};
    push_frame(frame);
    // Plain group closed by the delimiter.
    frame = '{8'h03, 8'h11, 8'h22, 8'h00};
    push_frame(frame);
    // Zero code byte before the end, later bytes ignored.
    frame = '{8'h00, 8'h05};
    push_frame(frame);
    // Zero inside a group and all-ones data, then an inserted zero.
    frame = '{8'h03, 8'h00, 8'hFF, 8'h01};
    push_frame(frame);
    // Delimiter inside a group.
    frame = '{8'h04, 8'hAA, 8'h00};
    push_frame(frame);
    // Last byte is a code byte that opens a group.
    frame = '{8'h05};
    push_frame(frame);
    // Data byte on the last beat with the group still open.
    frame = '{8'h04, 8'hBB, 8'hCC};
    push_frame(frame);
    frame = '{8'h02, 8'hFF, 8'h00};
    push_frame(frame);
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    idle_on    = 1'b1;
    bytes_sent = 0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(300);

    // Zero limit: every emission overflows.
    write_limit('0);
    run_random(120);
    write_limit(13'd1);
    run_random(120);

    // Largest register value, run with no idling on either side.
    write_limit(13'h1FFF);
    idle_on = 1'b0;
    run_random(200);
    idle_on = 1'b1;

    write_limit(13'($urandom_range(40, 2)));
    run_random(150);
    write_limit(cobs_fd_pkg::MAX_LEN_RESET);
    run_random(150);

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
